// ===== rtl/ctw_pkg.sv =====
// shared types and constants for the text console writer
// no dependencies; every other file of the block but ctw_ram imports this package
package ctw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // fixed field widths
  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ATTR_W = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0B;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // controller to datapath
  typedef struct packed {
    logic accept;       // input beat taken this cycle
    logic cnt_clr;
    logic cnt_bottom;   // load sweep counter with first cell of bottom row
    logic cnt_inc;
    logic copy_rd;      // read cell one row below the counter
    logic copy_wr;      // write read data one cell behind the counter
    logic fill_wr;      // write blank at the counter
    logic fill_reset;   // blank uses reset attribute
    logic val_capture;  // take ram read data as result value
    logic out_load;     // load output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  put_scroll;     // this put moves the cursor past the last row
    logic  idx_ok;         // read index inside the screen
    logic  cnt_zero;
    logic  cnt_last_copy;  // counter at first cell of bottom row
    logic  cnt_last;       // counter at last cell
  } ctl_sts_t;

endpackage

// ===== rtl/ctw_intf.sv =====
// valid/ready channel interfaces for input items and result items
// depends on ctw_pkg for field widths
interface ctw_in_if;
  import ctw_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output mode, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input mode, input char_code, input cell_index,
                  output ready);
endinterface

interface ctw_out_if;
  import ctw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;

  modport source (output valid, output cell_value, output cursor_row, output cursor_col,
                  input ready);
  modport sink   (input valid, input cell_value, input cursor_row, input cursor_col,
                  output ready);
endinterface

// ===== rtl/ctw_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module ctw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/ctw_ctl.sv =====
// controller state machine of the text console writer
// depends on ctw_pkg for command and status structs
module ctw_ctl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ctw_pkg::ctl_sts_t sts_i,
  output ctw_pkg::ctl_cmd_t cmd_o
);
  import ctw_pkg::*;

  typedef enum logic [5:0] {
    ST_INIT = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_READ = 6'b000100,
    ST_COPY = 6'b001000,
    ST_FILL = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;
  ctl_cmd_t cmd;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd.fill_wr    = 1'b1;
        cmd.fill_reset = 1'b1;
        cmd.cnt_inc    = 1'b1;
        if (sts_i.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          unique case (sts_i.mode)
            MODE_PUT:   state_d = sts_i.put_scroll ? ST_COPY : ST_DONE;
            MODE_CLEAR: state_d = ST_FILL;
            MODE_READ:  state_d = sts_i.idx_ok ? ST_READ : ST_DONE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        cmd.val_capture = 1'b1;
        state_d         = ST_DONE;
      end
      ST_COPY: begin
        cmd.copy_rd = !sts_i.cnt_last_copy;
        cmd.copy_wr = !sts_i.cnt_zero;
        if (sts_i.cnt_last_copy) begin
          cmd.cnt_bottom = 1'b1;
          state_d        = ST_FILL;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  // read wait is entered only straight after an accepted beat
  a_read_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> ($past(state_q) == ST_IDLE && $past(in_valid_i)))
    else $error("read wait without accepted beat");

  // one write source at a time on the ram
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.fill_wr && cmd.copy_wr) && !(cmd.accept && (cmd.fill_wr || cmd.copy_wr)))
    else $error("ram write port conflict");

  // copy sweep always hands over to the bottom row blanking
  a_copy_to_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY && sts_i.cnt_last_copy) |=> (state_q == ST_FILL))
    else $error("scroll did not blank bottom row");
endmodule

// ===== rtl/ctw_dp.sv =====
// datapath of the text console writer: cursor, attribute, sweep counter, cell store
// depends on ctw_pkg and ctw_ram
module ctw_dp #(
  parameter int COLUMNS = ctw_pkg::COLUMNS_DEF,
  parameter int ROWS    = ctw_pkg::ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctw_pkg::ctl_cmd_t          cmd_i,
  output ctw_pkg::ctl_sts_t          sts_o,
  input  logic [ctw_pkg::MODE_W-1:0] in_mode_i,
  input  logic [ctw_pkg::CHAR_W-1:0] in_char_i,
  input  logic [ctw_pkg::IDX_W-1:0]  in_idx_i,
  input  logic                       cfg_we_i,
  input  logic [ctw_pkg::ATTR_W-1:0] cfg_wdata_i,
  output logic [ctw_pkg::CELL_W-1:0] out_cell_o,
  output logic [ctw_pkg::ROW_W-1:0]  out_row_o,
  output logic [ctw_pkg::COL_W-1:0]  out_col_o
);
  import ctw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  logic [ATTR_W-1:0] attr_q;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [CELL_W-1:0] value_q;
  logic [CELL_W-1:0] out_cell_q;
  logic [RW-1:0]     out_row_q;
  logic [CW-1:0]     out_col_q;

  mode_e             mode;
  logic              is_newline, at_last_col, at_last_row, put_acc, put_wr;
  logic              read_acc;
  logic [AW-1:0]     put_addr;
  logic [AW:0]       cnt_below;
  logic [AW+IDX_W-1:0] idx_ext;
  logic [CELL_W-1:0] blank;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  logic [RW+ROW_W-1:0] row_ext;
  logic [CW+COL_W-1:0] col_ext;

  assign mode        = mode_e'(in_mode_i);
  assign is_newline  = (in_char_i == NEWLINE_CODE);
  assign at_last_col = (col_q == CW'(COLUMNS - 1));
  assign at_last_row = (row_q == RW'(ROWS - 1));
  assign put_acc     = cmd_i.accept && (mode == MODE_PUT);
  assign put_wr      = put_acc && !is_newline;
  assign read_acc    = cmd_i.accept && (mode == MODE_READ);

  assign put_addr  = AW'(32'(row_q) * COLUMNS + 32'(col_q));
  assign cnt_below = {1'b0, cnt_q} + (AW+1)'(COLUMNS);
  assign idx_ext   = {{AW{1'b0}}, in_idx_i};
  assign blank     = cmd_i.fill_reset ? {ATTR_RESET, SPACE_CODE} : {attr_q, SPACE_CODE};

  // cursor movement
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (put_acc) begin
      if (is_newline || at_last_col) begin
        col_d = '0;
        // past the last row the screen scrolls and the cursor stays on it
        if (!at_last_row) begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end else if (cmd_i.accept && mode == MODE_CLEAR) begin
      row_d = '0;
      col_d = '0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_bottom) begin
      cnt_d = AW'(CELLS - COLUMNS);
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + AW'(1);
    end
  end

  // ram port selection
  always_comb begin
    ram_we    = put_wr || cmd_i.copy_wr || cmd_i.fill_wr;
    ram_waddr = put_addr;
    ram_wdata = {attr_q, in_char_i};
    if (cmd_i.copy_wr) begin
      ram_waddr = cnt_q - AW'(1);
      ram_wdata = ram_rdata;
    end else if (cmd_i.fill_wr) begin
      ram_waddr = cnt_q;
      ram_wdata = blank;
    end
    ram_re    = (read_acc && sts_o.idx_ok) || cmd_i.copy_rd;
    ram_raddr = cmd_i.copy_rd ? cnt_below[AW-1:0] : idx_ext[AW-1:0];
  end

  ctw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
      row_q  <= '0;
      col_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      row_q <= row_d;
      col_q <= col_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      value_q <= '0;
    end else if (cmd_i.val_capture) begin
      value_q <= ram_rdata;
    end
    if (cmd_i.out_load) begin
      out_cell_q <= value_q;
      out_row_q  <= row_q;
      out_col_q  <= col_q;
    end
  end

  assign sts_o.mode          = mode;
  assign sts_o.put_scroll    = (is_newline || at_last_col) && at_last_row;
  assign sts_o.idx_ok        = (32'(in_idx_i) < CELLS);
  assign sts_o.cnt_zero      = (cnt_q == '0);
  assign sts_o.cnt_last_copy = (cnt_q == AW'(CELLS - COLUMNS));
  assign sts_o.cnt_last      = (cnt_q == AW'(CELLS - 1));

  assign row_ext    = {{ROW_W{1'b0}}, out_row_q};
  assign col_ext    = {{COL_W{1'b0}}, out_col_q};
  assign out_cell_o = out_cell_q;
  assign out_row_o  = row_ext[ROW_W-1:0];
  assign out_col_o  = col_ext[COL_W-1:0];
endmodule

// ===== rtl/text_console_writer_core.sv =====
// top level of the text console writer
// depends on ctw_pkg, ctw_intf, ctw_ram, ctw_ctl and ctw_dp

// Text console writer: keeps a ROWS x COLUMNS store of 16-bit cells (attribute
// in the high byte, character in the low byte) and a cursor. Each input beat
// gives exactly one result beat carrying the read cell value (zero unless a
// read) and the cursor after the item. A put or newline that stays on screen
// goes straight to its result, as do a read past the end of the screen and
// the unused mode; a read inside the screen first waits for the registered
// store read; a clear blanks the whole store and a put that scrolls copies
// it one row up and then blanks the bottom row; these sweep the cell store
// (one write port, one read port) one cell a cycle. After reset the block
// blanks every cell of the store to 0x0B20 before it takes the first input beat;
// attribute writes are taken at any time. The next input beat is taken while a
// result still waits at the output register.
module text_console_writer_core #(
  parameter int COLUMNS = ctw_pkg::COLUMNS_DEF,
  parameter int ROWS    = ctw_pkg::ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ctw_in_if.sink                     in_i,
  ctw_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [ctw_pkg::ATTR_W-1:0] cfg_wdata_i
);
  import ctw_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     in_ready, out_valid;

  // sequencing: accept, read wait, scroll copy, blank sweep, result hand-off
  ctw_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // cursor, attribute register, cell store and output register
  ctw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_mode_i   (in_i.mode),
    .in_char_i   (in_i.char_code),
    .in_idx_i    (in_i.cell_index),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_cell_o  (out_o.cell_value),
    .out_row_o   (out_o.cursor_row),
    .out_col_o   (out_o.cursor_col)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for text_console_writer_core: put, clear, read and unused
// mode beats are checked against a cycle-free mirror of the screen store and cursor
// depends on ctw_pkg, ctw_intf and the block's rtl only
module tb_top;
  import ctw_pkg::*;

  localparam int COLUMNS     = COLUMNS_DEF;
  localparam int ROWS        = ROWS_DEF;
  localparam int CELL_COUNT  = COLUMNS * ROWS;
  localparam int HOLD_CYCLES = 400;

  // one result beat as the block should present it
  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_result_t;

  // mirror of the screen store, cursor and attribute, plus the results still owed
  class console_mirror;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    int                row;
    int                col;
    logic [ATTR_W-1:0] attr;
    console_result_t   awaited[$];
    int unsigned       mismatches;

    function new();
      foreach (cells[k]) cells[k] = {ATTR_RESET, SPACE_CODE};
      row        = 0;
      col        = 0;
      attr       = ATTR_RESET;
      mismatches = 0;
    endfunction

    function logic [CELL_W-1:0] blank();
      return {attr, SPACE_CODE};
    endfunction

    // apply one accepted input beat and queue the result it must give
    function void note_item(mode_e m, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
      console_result_t r;
      r.value = '0;
      case (m)
        MODE_PUT: begin
          if (ch == NEWLINE_CODE) begin
            col = 0;
            row++;
          end else begin
            cells[row*COLUMNS + col] = {attr, ch};
            col++;
            if (col >= COLUMNS) begin
              col = 0;
              row++;
            end
          end
          // ran off the bottom: move everything up a row, blank the last one
          if (row >= ROWS) begin
            for (int k = 0; k < CELL_COUNT - COLUMNS; k++) cells[k] = cells[k + COLUMNS];
            for (int k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++) cells[k] = blank();
            row = ROWS - 1;
          end
        end
        MODE_CLEAR: begin
          foreach (cells[k]) cells[k] = blank();
          row = 0;
          col = 0;
        end
        MODE_READ: begin
          if (idx < CELL_COUNT) r.value = cells[idx];
        end
        default: ;
      endcase
      r.row = ROW_W'(row);
      r.col = COL_W'(col);
      awaited.push_back(r);
    endfunction

    // compare one result beat against the oldest owed result
    function void check_result(logic [CELL_W-1:0] v, logic [ROW_W-1:0] r,
                               logic [COL_W-1:0] c);
      console_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: value %h row %0d col %0d", v, r, c);
        return;
      end
      want = awaited.pop_front();
      if (v !== want.value || r !== want.row || c !== want.col) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected value %h row %0d col %0d, ",
                    "got value %h row %0d col %0d"},
                   want.value, want.row, want.col, v, r, c);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ATTR_W-1:0] cfg_wdata_i;

  ctw_in_if  item_if ();
  ctw_out_if result_if ();

  console_mirror sb;

  // random idling on both sides; off for one whole phase
  bit          idle_on   = 1'b1;
  // bumped by the stimulus to make the result side hold off for a long stretch
  int unsigned hold_asks = 0;

  text_console_writer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (item_if),
    .out_o       (result_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous ceiling: even every beat scrolling with long stalls ends far sooner
  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  // offer one input beat, with random idle cycles ahead of it, and wait for it to go
  task automatic send_item(input mode_e m, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    while (idle_on && $urandom_range(99) < 25) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.mode       <= m;
    item_if.char_code  <= ch;
    item_if.cell_index <= idx;
    // values seen just after the edge are the ones the edge sampled
    do @(posedge clk_i); while (!item_if.ready);
    sb.note_item(m, ch, idx);
  endtask

  // stop offering and wait until every owed result beat has been seen
  task automatic settle();
    item_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  // attribute write, only ever done with the block idle
  task automatic write_attribute(input logic [ATTR_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.attr = v;
  endtask

  // one random run of console traffic; returns how many beats it sent
  task automatic send_burst(output int unsigned count);
    int unsigned       pick;
    int unsigned       len;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    pick  = $urandom_range(99);
    count = 0;
    if (pick < 55) begin
      // short text line ended by a newline, or a long run that can wrap
      len = (pick < 45) ? $urandom_range(4) : $urandom_range(90, 70);
      repeat (len) begin
        ch = CHAR_W'($urandom_range(255));
        if (ch == NEWLINE_CODE) ch = SPACE_CODE;
        send_item(MODE_PUT, ch, IDX_W'($urandom_range(2047)));
        count++;
      end
      if (pick < 45) begin
        send_item(MODE_PUT, NEWLINE_CODE, IDX_W'($urandom_range(2047)));
        count++;
      end
    end else if (pick < 67) begin
      // run of blank lines, which can push the cursor off the bottom
      len = $urandom_range(20, 5);
      repeat (len) send_item(MODE_PUT, NEWLINE_CODE, IDX_W'($urandom_range(2047)));
      count += len;
    end else if (pick < 92) begin
      // display fetches: anywhere, around the cursor row, or past the screen
      len = $urandom_range(5, 1);
      repeat (len) begin
        pick = $urandom_range(9);
        if (pick < 6)
          idx = IDX_W'($urandom_range(CELL_COUNT - 1));
        else if (pick < 8)
          idx = IDX_W'(sb.row * COLUMNS + $urandom_range(COLUMNS - 1));
        else
          idx = IDX_W'($urandom_range(2047, CELL_COUNT));
        send_item(MODE_READ, CHAR_W'($urandom_range(255)), idx);
      end
      count += len;
    end else if (pick < 94) begin
      send_item(MODE_CLEAR, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
      count = 1;
    end else begin
      // noise: any mode, any field values, the unused mode included
      len = $urandom_range(3, 1);
      repeat (len)
        send_item(mode_e'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                  IDX_W'($urandom_range(2047)));
      count += len;
    end
  endtask

  // result side: checks every beat taken, idles at random, serves long hold-offs
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid && result_if.ready)
        sb.check_result(result_if.cell_value, result_if.cursor_row, result_if.cursor_col);
      if (holds_served != hold_asks) begin
        holds_served = hold_asks;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= !(idle_on && $urandom_range(99) < 25);
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_items;
    int unsigned got;
    sb = new();
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_wdata_i           <= '0;
    item_if.valid         <= 1'b0;
    item_if.mode          <= MODE_PUT;
    item_if.char_code     <= '0;
    item_if.cell_index    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset contents, both ends of the store and reads past the end
    // (the first beat waits out the blanking sweep after reset)
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'hFF, 11'd1999);
    send_item(MODE_READ, 8'h00, 11'd2000);
    send_item(MODE_READ, 8'h00, 11'h7FF);
    // lowest, highest and high-half character bytes, index ignored on a put
    send_item(MODE_PUT, 8'h00, 11'h7FF);
    send_item(MODE_PUT, 8'hFF, 11'd0);
    send_item(MODE_PUT, 8'h80, 11'd0);
    send_item(MODE_PUT, 8'h7F, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd1);
    send_item(MODE_READ, 8'h00, 11'd2);
    send_item(MODE_PUT, NEWLINE_CODE, 11'd0);
    // unused mode changes nothing whatever the fields hold
    send_item(MODE_NONE, 8'hFF, 11'h7FF);
    send_item(MODE_NONE, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd80);
    settle();

    // clear with the top attribute, fields ignored
    write_attribute(8'hFF);
    send_item(MODE_CLEAR, 8'hFF, 11'h7FF);
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd1999);
    send_item(MODE_PUT, 8'h41, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd0);
    settle();

    // zero attribute
    write_attribute(8'h00);
    send_item(MODE_PUT, SPACE_CODE, 11'd0);
    send_item(MODE_READ, 8'hFF, 11'h7FF);
    send_item(MODE_PUT, NEWLINE_CODE, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd1);
    settle();

    // random phases, each under its own attribute
    for (int p = 0; p < 4; p++) begin
      write_attribute(ATTR_W'($urandom_range(255)));
      // phase two runs flat out with no idling on either side
      idle_on = (p != 2);
      // long result hold-off while beats keep coming, to back the block up
      if (p == 1 || p == 3) hold_asks++;
      phase_items = 0;
      while (phase_items < 70) begin
        send_burst(got);
        phase_items += got;
      end
      settle();
    end

    // catch any stray beat after the last owed one
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.awaited.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
